FILE: hw/rtl/pnorm_pkg.sv
// ---------------------------------------------------------------------------
// Path normalizer package
// Shared sizes, codes and the command format between front and back parts.
// ---------------------------------------------------------------------------
package pnorm_pkg;

  // Stack and store sizing.
  localparam int MAX_COMPONENTS      = 16;
  localparam int MAX_COMPONENT_CHARS = 31;
  localparam int STORE_DEPTH = MAX_COMPONENTS * (MAX_COMPONENT_CHARS + 1)
                             + MAX_COMPONENT_CHARS + 1;
  localparam int ADDR_W = $clog2(STORE_DEPTH);
  localparam int CNT_W  = $clog2(MAX_COMPONENTS + 1);
  localparam int IDX_W  = $clog2(MAX_COMPONENTS);
  localparam int CLEN_W = $clog2(MAX_COMPONENT_CHARS + 1);

  // Field widths of the channels and the register.
  localparam int CHAR_W      = 8;
  localparam int RIDX_W      = 9;
  localparam int OLEN_W      = 9;
  localparam int CAP_W       = 10;
  localparam int TDATA_IN_W  = 24;
  localparam int TDATA_OUT_W = 24;
  localparam logic [CAP_W-1:0] CAP_RESET = 10'd64;

  // Common compare width for offsets, read indexes and the capacity.
  localparam int CMP_A = (ADDR_W > RIDX_W) ? ADDR_W : RIDX_W;
  localparam int CMP_W = ((CMP_A > CAP_W) ? CMP_A : CAP_W) + 1;

  // Command queue between front and back.
  localparam int QUEUE_DEPTH = 4;

  // Characters with a meaning of their own.
  localparam logic [CHAR_W-1:0] SEP_SLASH = 8'h2F;
  localparam logic [CHAR_W-1:0] SEP_BACK  = 8'h5C;
  localparam logic [CHAR_W-1:0] DOT       = 8'h2E;

  typedef enum logic [1:0] {
    OP_BASE   = 2'd0,
    OP_PATH   = 2'd1,
    OP_FINISH = 2'd2,
    OP_READ   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_LONG = 2'd1,
    ST_MANY = 2'd2,
    ST_ROOM = 2'd3
  } status_e;

  // One queued command: up to two store writes and an optional result.
  typedef struct packed {
    logic                sep_we;
    logic [ADDR_W-1:0]   sep_addr;
    logic                chr_we;
    logic [ADDR_W-1:0]   chr_addr;
    logic [CHAR_W-1:0]   chr;
    logic                is_result;
    logic                rd_en;
    logic [ADDR_W-1:0]   raddr;
    status_e             status;
    logic [OLEN_W-1:0]   length;
  } cmd_t;

endpackage

FILE: hw/rtl/path_normalizer_unit.sv
// ---------------------------------------------------------------------------
// Path normalizer unit
// Streaming path canonicalizer with a component stack and a character store.
// ---------------------------------------------------------------------------
// Items enter on the s_ channel: tuser carries the op (base character, path
// character, finish, read) and tdata the character and the read index. Finish
// and read items each return one item on the m_ channel with the status, the
// length and, for reads after finish, the output character. The capacity
// register is written on the cfg channel; the user must write it only while
// the unit is idle, as the block does not enforce this. Throughput is one
// item per cycle while the command queue has room. The single store write
// port makes the first path character after a pending base component, when
// it writes a separator and the character, hold the queue head while the
// separator goes first. Each result item passes the command queue, the read
// stage and the output register. Reset clears the request state and the queue
// and sets the capacity to 64; the store is not cleared and needs no clearing
// pass. When the receiver stalls, the output register, the read stage and the
// four-entry command queue fill up, and only then does s_tready_o drop.
// ---------------------------------------------------------------------------
module path_normalizer_unit
  import pnorm_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_tvalid_i,
  output logic                   s_tready_o,
  // in_char [7:0], read_index [16:8], zero [23:17]
  input  logic [TDATA_IN_W-1:0]  s_tdata_i,
  // op [1:0]
  input  logic [1:0]             s_tuser_i,
  output logic                   m_tvalid_o,
  input  logic                   m_tready_i,
  // status [1:0], out_length [10:2], out_char [18:11], zero [23:19]
  output logic [TDATA_OUT_W-1:0] m_tdata_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CAP_W-1:0]       cfg_data_i
);

  logic              q_full, q_push, q_empty, q_pop;
  cmd_t              q_cmd, q_head;
  status_e           m_status;
  logic [OLEN_W-1:0] m_length;
  logic [CHAR_W-1:0] m_char;

  assign cfg_ready_o = 1'b1;

  pnorm_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (s_tvalid_i),
    .ready_o      (s_tready_o),
    .op_i         (op_e'(s_tuser_i)),
    .in_char_i    (s_tdata_i[CHAR_W-1:0]),
    .read_index_i (s_tdata_i[CHAR_W+RIDX_W-1:CHAR_W]),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_cmd_o      (q_cmd)
  );

  pnorm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (q_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .head_o  (q_head)
  );

  pnorm_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (!q_empty),
    .head_i       (q_head),
    .pop_o        (q_pop),
    .m_valid_o    (m_tvalid_o),
    .m_ready_i    (m_tready_i),
    .m_status_o   (m_status),
    .m_length_o   (m_length),
    .m_char_o     (m_char)
  );

  // Pack the result fields, lowest field first.
  assign m_tdata_o = {{(TDATA_OUT_W - 2 - OLEN_W - CHAR_W){1'b0}},
                      m_char, m_length, m_status};

`ifndef SYNTH
  // The front never pushes a command into a full queue.
  a_queue_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("command pushed into a full queue");

  // A failing status always comes with a zero length.
  a_length_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && (m_status != ST_OK)) |-> (m_length == '0))
    else $error("nonzero length with a failing status");

  // A failing status always comes with a zero character.
  a_char_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && (m_status != ST_OK)) |-> (m_char == '0))
    else $error("nonzero character with a failing status");

  // The back part pops only when the queue holds an entry.
  a_pop_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("command popped from an empty queue");
`endif

endmodule

FILE: hw/rtl/pnorm_ram.sv
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module pnorm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port; read data holds between reads.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/pnorm_front.sv
// ---------------------------------------------------------------------------
// Path normalizer front part
// Accepts items, tracks the component stack and emits store commands.
// ---------------------------------------------------------------------------
module pnorm_front
  import pnorm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  op_e               op_i,
  input  logic [CHAR_W-1:0] in_char_i,
  input  logic [RIDX_W-1:0] read_index_i,
  input  logic              cfg_valid_i,
  input  logic [CAP_W-1:0]  cfg_data_i,
  input  logic              q_full_i,
  output logic              q_push_o,
  output cmd_t              q_cmd_o
);

  typedef struct packed {
    logic [CNT_W-1:0]    count;
    logic [ADDR_W-1:0]   tail;
    logic [CLEN_W-1:0]   cur_len;
    logic [2*CHAR_W-1:0] first_two;
    status_e             err;
  } req_t;

  typedef struct packed {
    req_t              r;
    logic              push;
    logic [IDX_W-1:0]  push_idx;
    logic [ADDR_W-1:0] push_start;
    logic              sep_we;
    logic [ADDR_W-1:0] sep_addr;
    logic              chr_we;
    logic [ADDR_W-1:0] chr_addr;
    logic [CHAR_W-1:0] chr;
  } act_t;

  // Request state.
  logic [CNT_W-1:0]    count_q, count_d;
  logic [ADDR_W-1:0]   tail_q, tail_d;
  logic [CLEN_W-1:0]   cur_len_q, cur_len_d;
  logic [2*CHAR_W-1:0] first_two_q, first_two_d;
  status_e             err_q, err_d;
  logic                started_q, started_d;
  logic                done_q, done_d;
  logic [CAP_W-1:0]    cap_q, cap_d;
  logic [ADDR_W-1:0]   starts_q [MAX_COMPONENTS];

  logic              accept;
  logic [IDX_W-1:0]  pop_idx;
  logic [ADDR_W-1:0] pop_tail;
  logic              started_cur;
  act_t              act;
  status_e           status;
  logic [CMP_W-1:0]  tail_ext;
  logic [CMP_W-1:0]  idx_ext;

  function automatic logic is_sep(input logic [CHAR_W-1:0] c);
    return (c == SEP_SLASH) || (c == SEP_BACK);
  endfunction

  function automatic req_t clear_req(input req_t r_in);
    req_t r;
    r           = r_in;
    r.count     = '0;
    r.tail      = '0;
    r.cur_len   = '0;
    r.first_two = '0;
    r.err       = ST_OK;
    return r;
  endfunction

  // Closes the pending component: skip, pop, push or too-many error.
  function automatic act_t end_comp(input act_t a_in, input logic [ADDR_W-1:0] ptail);
    act_t              a;
    logic [CLEN_W-1:0] len;
    logic [CHAR_W-1:0] first;
    logic [CHAR_W-1:0] second;
    logic [ADDR_W-1:0] start;
    a           = a_in;
    len         = a.r.cur_len;
    first       = a.r.first_two[CHAR_W-1:0];
    second      = a.r.first_two[2*CHAR_W-1:CHAR_W];
    a.r.cur_len   = '0;
    a.r.first_two = '0;
    if ((len == '0) || (a.r.err != ST_OK)) begin
      return a;
    end
    if ((len == CLEN_W'(1)) && (first == DOT)) begin
      return a;
    end
    if ((len == CLEN_W'(2)) && (first == DOT) && (second == DOT)) begin
      if (a.r.count != '0) begin
        a.r.count = a.r.count - CNT_W'(1);
        a.r.tail  = (a.r.count == '0) ? '0 : ptail;
      end
      return a;
    end
    if (a.r.count >= CNT_W'(MAX_COMPONENTS)) begin
      a.r.err = ST_MANY;
      return a;
    end
    start = (a.r.count == '0) ? '0 : a.r.tail + ADDR_W'(1);
    if (a.r.count != '0) begin
      a.sep_we   = 1'b1;
      a.sep_addr = a.r.tail;
    end
    a.push       = 1'b1;
    a.push_idx   = a.r.count[IDX_W-1:0];
    a.push_start = start;
    a.r.tail     = start + ADDR_W'(len);
    a.r.count    = a.r.count + CNT_W'(1);
    return a;
  endfunction

  // Handles one character: separator, append, or overlong component.
  function automatic act_t take_char(input act_t a_in, input logic [CHAR_W-1:0] c,
                                     input logic [ADDR_W-1:0] ptail);
    act_t              a;
    logic [ADDR_W-1:0] pstart;
    a = a_in;
    if (a.r.err != ST_OK) begin
      return a;
    end
    if (is_sep(c)) begin
      return end_comp(a, ptail);
    end
    if (a.r.cur_len >= CLEN_W'(MAX_COMPONENT_CHARS)) begin
      a.r.err = ST_LONG;
      return a;
    end
    pstart     = (a.r.count == '0) ? '0 : a.r.tail + ADDR_W'(1);
    a.chr_we   = 1'b1;
    a.chr_addr = pstart + ADDR_W'(a.r.cur_len);
    a.chr      = c;
    if (a.r.cur_len == '0) begin
      a.r.first_two = {{CHAR_W{1'b0}}, c};
    end else if (a.r.cur_len == CLEN_W'(1)) begin
      a.r.first_two[2*CHAR_W-1:CHAR_W] = c;
    end
    a.r.cur_len = a.r.cur_len + CLEN_W'(1);
    return a;
  endfunction

  assign accept  = valid_i && !q_full_i;
  assign ready_o = !q_full_i;

  // Offset that a pop leaves as the committed tail.
  assign pop_idx  = (count_q == '0) ? '0 : IDX_W'(count_q - CNT_W'(1));
  assign pop_tail = starts_q[pop_idx] - ADDR_W'(1);

  // Item decode and request state update.
  always_comb begin
    act         = '0;
    act.r.count     = count_q;
    act.r.tail      = tail_q;
    act.r.cur_len   = cur_len_q;
    act.r.first_two = first_two_q;
    act.r.err       = err_q;
    started_d   = started_q;
    done_d      = done_q;
    started_cur = started_q;
    if (accept) begin
      unique case (op_i) inside
        OP_BASE, OP_PATH: begin
          if (done_q) begin
            act.r       = clear_req(act.r);
            started_d   = 1'b0;
            started_cur = 1'b0;
            done_d      = 1'b0;
          end
          if (op_i == OP_BASE) begin
            if (!started_cur) begin
              act = take_char(act, in_char_i, pop_tail);
            end
          end else begin
            if (!started_cur) begin
              started_d = 1'b1;
              act       = end_comp(act, pop_tail);
              if (is_sep(in_char_i)) begin
                act.r = clear_req(act.r);
              end
            end
            act = take_char(act, in_char_i, pop_tail);
          end
        end
        OP_FINISH: begin
          if (!done_q) begin
            act    = end_comp(act, pop_tail);
            done_d = 1'b1;
          end
        end
        OP_READ: begin
        end
        default: begin
        end
      endcase
    end
    count_d     = act.r.count;
    tail_d      = act.r.tail;
    cur_len_d   = act.r.cur_len;
    first_two_d = act.r.first_two;
    err_d       = act.r.err;
  end

  // Status and read request from the updated state.
  assign tail_ext = CMP_W'(act.r.tail);
  assign idx_ext  = CMP_W'(read_index_i);

  always_comb begin
    if (act.r.err != ST_OK) begin
      status = act.r.err;
    end else if (tail_ext + CMP_W'(1) > CMP_W'(cap_q)) begin
      status = ST_ROOM;
    end else begin
      status = ST_OK;
    end
  end

  always_comb begin
    q_cmd_o           = '0;
    q_cmd_o.sep_we    = act.sep_we;
    q_cmd_o.sep_addr  = act.sep_addr;
    q_cmd_o.chr_we    = act.chr_we;
    q_cmd_o.chr_addr  = act.chr_addr;
    q_cmd_o.chr       = act.chr;
    q_cmd_o.is_result = (op_i == OP_FINISH) || (op_i == OP_READ);
    q_cmd_o.rd_en     = (op_i == OP_READ) && done_d && (status == ST_OK)
                        && (idx_ext < tail_ext);
    q_cmd_o.raddr     = idx_ext[ADDR_W-1:0];
    q_cmd_o.status    = status;
    q_cmd_o.length    = (status == ST_OK) ? tail_ext[OLEN_W-1:0] : '0;
  end

  assign q_push_o = accept && (q_cmd_o.is_result || act.sep_we || act.chr_we);

  // Configuration register.
  assign cap_d = cfg_valid_i ? cfg_data_i : cap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      tail_q      <= '0;
      cur_len_q   <= '0;
      first_two_q <= '0;
      err_q       <= ST_OK;
      started_q   <= 1'b0;
      done_q      <= 1'b1;
      cap_q       <= CAP_RESET;
    end else begin
      count_q     <= count_d;
      tail_q      <= tail_d;
      cur_len_q   <= cur_len_d;
      first_two_q <= first_two_d;
      err_q       <= err_d;
      started_q   <= started_d;
      done_q      <= done_d;
      cap_q       <= cap_d;
    end
  end

  // Component start offsets.
  always_ff @(posedge clk_i) begin
    if (accept && act.push) begin
      starts_q[act.push_idx] <= act.push_start;
    end
  end

endmodule

FILE: hw/rtl/pnorm_queue.sv
// ---------------------------------------------------------------------------
// Path normalizer command queue
// Short first-in first-out buffer between the front and back parts.
// ---------------------------------------------------------------------------
module pnorm_queue
  import pnorm_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output cmd_t head_o
);

  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t              slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] fill_q, fill_d;
  logic              do_push, do_pop;

  assign full_o  = (fill_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o = (fill_q == '0);
  assign head_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Pointer and fill bookkeeping.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      fill_d = fill_q + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      fill_d = fill_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

FILE: hw/rtl/pnorm_back.sv
// ---------------------------------------------------------------------------
// Path normalizer back part
// Carries out store writes and reads and delivers result items.
// ---------------------------------------------------------------------------
module pnorm_back
  import pnorm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              head_valid_i,
  input  cmd_t              head_i,
  output logic              pop_o,
  output logic              m_valid_o,
  input  logic              m_ready_i,
  output status_e           m_status_o,
  output logic [OLEN_W-1:0] m_length_o,
  output logic [CHAR_W-1:0] m_char_o
);

  logic              first_done_q, first_done_d;
  logic              two_left;
  logic              s1_valid_q, s1_valid_d;
  logic              s1_move, s1_free;
  status_e           s1_status_q;
  logic [OLEN_W-1:0] s1_length_q;
  logic              s1_rd_q;
  logic              out_valid_q, out_valid_d;
  status_e           out_status_q;
  logic [OLEN_W-1:0] out_length_q;
  logic [CHAR_W-1:0] out_char_q;
  logic              take_first;
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr;
  logic [CHAR_W-1:0] ram_wdata;
  logic [CHAR_W-1:0] ram_rdata;

  // Pipeline flow: read stage then output register.
  assign s1_move  = s1_valid_q && (!out_valid_q || m_ready_i);
  assign s1_free  = !s1_valid_q || s1_move;
  assign two_left = head_valid_i && head_i.sep_we && head_i.chr_we && !first_done_q;
  assign pop_o    = head_valid_i && !two_left && (!head_i.is_result || s1_free);

  // Write port: separator first, then the character.
  assign take_first = head_i.sep_we && !first_done_q;
  assign ram_we     = head_valid_i && (take_first || head_i.chr_we);
  assign ram_waddr  = take_first ? head_i.sep_addr : head_i.chr_addr;
  assign ram_wdata  = take_first ? SEP_SLASH : head_i.chr;
  assign ram_re     = pop_o && head_i.is_result && head_i.rd_en;

  pnorm_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (head_i.raddr),
    .rdata_o (ram_rdata)
  );

  // Control next state.
  always_comb begin
    first_done_d = first_done_q;
    if (two_left) begin
      first_done_d = 1'b1;
    end else if (pop_o) begin
      first_done_d = 1'b0;
    end
    s1_valid_d = s1_valid_q;
    if (pop_o && head_i.is_result) begin
      s1_valid_d = 1'b1;
    end else if (s1_move) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_move) begin
      out_valid_d = 1'b1;
    end else if (m_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_done_q <= 1'b0;
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      first_done_q <= first_done_d;
      s1_valid_q   <= s1_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Result payload registers.
  always_ff @(posedge clk_i) begin
    if (pop_o && head_i.is_result) begin
      s1_status_q <= head_i.status;
      s1_length_q <= head_i.length;
      s1_rd_q     <= head_i.rd_en;
    end
    if (s1_move) begin
      out_status_q <= s1_status_q;
      out_length_q <= s1_length_q;
      out_char_q   <= s1_rd_q ? ram_rdata : '0;
    end
  end

  assign m_valid_o  = out_valid_q;
  assign m_status_o = out_status_q;
  assign m_length_o = out_length_q;
  assign m_char_o   = out_char_q;

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Path normalizer unit testbench
// Sends base and path characters, finish and read items, and compares every
// result item with a cycle-free path model or a typed row's own expectation.
// ---------------------------------------------------------------------------
module tb_top;
  import pnorm_pkg::*;

  localparam int NUM_DIRECTED  = 27;
  localparam int RANDOM_ITEMS  = 1100;
  localparam int NUM_PHASES    = 6;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES   = 300;
  localparam int QUIET_LIMIT   = 5000;
  localparam int MAX_REPORTS   = 10;

  // One result item: status, length and character fields.
  typedef struct packed {
    status_e           status;
    logic [OLEN_W-1:0] length;
    logic [CHAR_W-1:0] chr;
  } path_result_t;

  // One directed item; the expected result is given only where typed is set.
  typedef struct packed {
    op_e               op;
    logic [CHAR_W-1:0] c;
    logic [RIDX_W-1:0] idx;
    logic              typed;
    status_e           st;
    logic [OLEN_W-1:0] len;
    logic [CHAR_W-1:0] ch;
  } stim_row_t;

  localparam stim_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
    '{OP_FINISH, 8'h00, 9'd0,   1'b1, ST_OK, 9'd0, 8'h00},  // finish right after reset
    '{OP_READ,   8'hFF, 9'd511, 1'b1, ST_OK, 9'd0, 8'h00},  // read at the root
    '{OP_BASE,   8'h61, 9'd0,   1'b0, ST_OK, 9'd0, 8'h00},
    '{OP_BASE,   8'hFF, 9'd511, 1'b0, ST_OK, 9'd0, 8'h00},
    '{OP_PATH,   DOT,   9'd0,   1'b0, ST_OK, 9'd0, 8'h00},  // path start ends base
    '{OP_PATH,   SEP_BACK, 9'd0, 1'b0, ST_OK, 9'd0, 8'h00}, // single dot is skipped
    '{OP_READ,   8'h00, 9'd0,   1'b1, ST_OK, 9'd2, 8'h00},  // read before finish
    '{OP_PATH,   8'h00, 9'd0,   1'b0, ST_OK, 9'd0, 8'h00},
    '{OP_PATH,   SEP_SLASH, 9'd0, 1'b0, ST_OK, 9'd0, 8'h00},
    '{OP_PATH,   DOT,   9'd0,   1'b0, ST_OK, 9'd0, 8'h00},
    '{OP_PATH,   DOT,   9'd0,   1'b0, ST_OK, 9'd0, 8'h00},
    '{OP_PATH,   SEP_SLASH, 9'd0, 1'b0, ST_OK, 9'd0, 8'h00}, // dot-dot pops
    '{OP_BASE,   8'h7A, 9'd0,   1'b0, ST_OK, 9'd0, 8'h00},  // late base char
    '{OP_PATH,   8'h71, 9'd0,   1'b0, ST_OK, 9'd0, 8'h00},
    '{OP_FINISH, 8'h00, 9'd0,   1'b0, ST_OK, 9'd0, 8'h00},
    '{OP_FINISH, 8'h00, 9'd0,   1'b0, ST_OK, 9'd0, 8'h00},  // repeated finish
    '{OP_READ,   8'h00, 9'd1,   1'b0, ST_OK, 9'd0, 8'h00},
    '{OP_READ,   8'h00, 9'd511, 1'b1, ST_OK, 9'd4, 8'h00},  // beyond the length
    '{OP_PATH,   SEP_SLASH, 9'd0, 1'b0, ST_OK, 9'd0, 8'h00}, // absolute, no base
    '{OP_PATH,   DOT,   9'd0,   1'b0, ST_OK, 9'd0, 8'h00},
    '{OP_PATH,   DOT,   9'd0,   1'b0, ST_OK, 9'd0, 8'h00},
    '{OP_FINISH, 8'h00, 9'd0,   1'b1, ST_OK, 9'd0, 8'h00},  // dot-dot at the root
    '{OP_BASE,   8'h61, 9'd0,   1'b0, ST_OK, 9'd0, 8'h00},
    '{OP_PATH,   SEP_BACK, 9'd0, 1'b0, ST_OK, 9'd0, 8'h00}, // absolute drops the base
    '{OP_PATH,   8'h62, 9'd0,   1'b0, ST_OK, 9'd0, 8'h00},
    '{OP_FINISH, 8'h00, 9'd0,   1'b0, ST_OK, 9'd0, 8'h00},
    '{OP_READ,   8'h00, 9'd0,   1'b0, ST_OK, 9'd0, 8'h00}
  };

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_tvalid_i;
  logic                   s_tready_o;
  // in_char [7:0], read_index [16:8], zero [23:17]
  logic [TDATA_IN_W-1:0]  s_tdata_i;
  // op [1:0]
  logic [1:0]             s_tuser_i;
  logic                   m_tvalid_o;
  logic                   m_tready_i;
  // status [1:0], out_length [10:2], out_char [18:11], zero [23:19]
  logic [TDATA_OUT_W-1:0] m_tdata_o;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [CAP_W-1:0]       cfg_data_i;

  // Model state of the canonical path builder.
  logic [CHAR_W-1:0] name_store [STORE_DEPTH];
  int unsigned       comp_start [MAX_COMPONENTS];
  int unsigned       comp_count;
  int unsigned       cur_len;
  int unsigned       tail_len;
  logic [CHAR_W-1:0] cur_first;
  logic [CHAR_W-1:0] cur_second;
  status_e           err_code;
  bit                path_begun;
  bit                req_closed;
  logic [CAP_W-1:0]  capacity_model;

  path_result_t pending_results [$];
  int           fail_count;
  int           items_sent;
  int           src_idle_pct;
  int           sink_idle_pct;
  bit           hold_pending;

  path_normalizer_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_tvalid_i),
    .s_tready_o  (s_tready_o),
    .s_tdata_i   (s_tdata_i),
    .s_tuser_i   (s_tuser_i),
    .m_tvalid_o  (m_tvalid_o),
    .m_tready_i  (m_tready_i),
    .m_tdata_o   (m_tdata_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---- Path model ----------------------------------------------------------

  function automatic bit is_separator(logic [CHAR_W-1:0] c);
    return c == SEP_SLASH || c == SEP_BACK;
  endfunction

  // Offset where the component being received starts.
  function automatic int unsigned next_start();
    return (comp_count == 0) ? 0 : tail_len + 1;
  endfunction

  function automatic void drop_request();
    comp_count = 0;
    tail_len   = 0;
    cur_len    = 0;
    cur_first  = '0;
    cur_second = '0;
    err_code   = ST_OK;
  endfunction

  // Commits, skips or pops the component being received, or flags too many.
  function automatic void close_component();
    int unsigned       len;
    int unsigned       start;
    logic [CHAR_W-1:0] c0;
    logic [CHAR_W-1:0] c1;
    len        = cur_len;
    c0         = cur_first;
    c1         = cur_second;
    cur_len    = 0;
    cur_first  = '0;
    cur_second = '0;
    if (len == 0 || err_code != ST_OK) return;
    if (len == 1 && c0 == DOT) return;
    if (len == 2 && c0 == DOT && c1 == DOT) begin
      if (comp_count > 0) begin
        comp_count--;
        tail_len = (comp_count == 0) ? 0 : comp_start[comp_count] - 1;
      end
      return;
    end
    if (comp_count >= MAX_COMPONENTS) begin
      err_code = ST_MANY;
      return;
    end
    start = next_start();
    if (comp_count > 0) name_store[tail_len] = SEP_SLASH;
    comp_start[comp_count] = start;
    tail_len = start + len;
    comp_count++;
  endfunction

  function automatic void absorb_char(logic [CHAR_W-1:0] c);
    if (err_code != ST_OK) return;
    if (is_separator(c)) begin
      close_component();
      return;
    end
    if (cur_len >= MAX_COMPONENT_CHARS) begin
      err_code = ST_LONG;
      return;
    end
    name_store[next_start() + cur_len] = c;
    if (cur_len == 0) cur_first = c;
    else if (cur_len == 1) cur_second = c;
    cur_len++;
  endfunction

  // Advances the model by one item; returns 1 when the item yields a result.
  function automatic bit predict_path(op_e op, logic [CHAR_W-1:0] c,
                                      logic [RIDX_W-1:0] idx, output path_result_t r);
    r.status = ST_OK;
    r.length = '0;
    r.chr    = '0;
    if (op == OP_BASE || op == OP_PATH) begin
      if (req_closed) begin
        drop_request();
        path_begun = 1'b0;
        req_closed = 1'b0;
      end
      if (op == OP_BASE) begin
        if (!path_begun) absorb_char(c);
        return 1'b0;
      end
      if (!path_begun) begin
        path_begun = 1'b1;
        close_component();
        if (is_separator(c)) drop_request();
      end
      absorb_char(c);
      return 1'b0;
    end
    if (op == OP_FINISH && !req_closed) begin
      close_component();
      req_closed = 1'b1;
    end
    if (err_code != ST_OK) r.status = err_code;
    else if (tail_len + 1 > capacity_model) r.status = ST_ROOM;
    if (r.status == ST_OK) r.length = tail_len[OLEN_W-1:0];
    if (op == OP_READ && req_closed && r.status == ST_OK && idx < tail_len)
      r.chr = name_store[idx];
    return 1'b1;
  endfunction

  // ---- Checking ------------------------------------------------------------

  function automatic void log_failure(string what);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("[%0t] %s", $time, what);
  endfunction

  // Each accepted result item is matched against the oldest expectation.
  always @(posedge clk_i) begin
    path_result_t got;
    path_result_t want;
    if (rst_ni && m_tvalid_o && m_tready_i) begin
      got.status = status_e'(m_tdata_o[1:0]);
      got.length = m_tdata_o[10:2];
      got.chr    = m_tdata_o[18:11];
      if (pending_results.size() == 0) begin
        log_failure($sformatf("unexpected result: status %0d len %0d char %02h",
                              got.status, got.length, got.chr));
      end else begin
        want = pending_results.pop_front();
        if (got.status != want.status || got.length != want.length ||
            got.chr != want.chr) begin
          log_failure($sformatf(
            "mismatch: expected status %0d len %0d char %02h, got status %0d len %0d char %02h",
            want.status, want.length, want.chr, got.status, got.length, got.chr));
        end
      end
    end
  end

  // Ends the run when no channel has moved an item for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((s_tvalid_i && s_tready_o) || (m_tvalid_o && m_tready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("** path_normalizer_unit: FAILED **");
    $finish;
  end

  // Result side: random stalls, plus one long hold-off when requested.
  initial begin : sink_proc
    int hold_left;
    hold_left  = 0;
    m_tready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_pending) begin
        hold_left    = HOLD_CYCLES;
        hold_pending = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready_i <= 1'b0;
      end else begin
        m_tready_i <= !(sink_idle_pct != 0 && $urandom_range(99) < sink_idle_pct);
      end
    end
  end

  // ---- Stimulus ------------------------------------------------------------

  // Offers one item and updates the model once it is taken.
  task automatic drive_item(op_e op, logic [CHAR_W-1:0] c, logic [RIDX_W-1:0] idx,
                            bit typed = 1'b0, path_result_t typed_res = '0);
    path_result_t r;
    while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      s_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tuser_i  <= op;
    s_tdata_i  <= {7'b0, idx, c};
    do @(posedge clk_i); while (!s_tready_o);
    if (predict_path(op, c, idx, r)) pending_results.push_back(typed ? typed_res : r);
    items_sent++;
  endtask

  task automatic drive_char(op_e op, logic [CHAR_W-1:0] c);
    drive_item(op, c, RIDX_W'($urandom_range(511)));
  endtask

  function automatic logic [CHAR_W-1:0] name_char();
    if ($urandom_range(9) == 0) return CHAR_W'($urandom_range(255));
    return CHAR_W'($urandom_range(97, 122));
  endfunction

  function automatic logic [CHAR_W-1:0] pick_sep();
    return $urandom_range(1) ? SEP_SLASH : SEP_BACK;
  endfunction

  // One component: a dot, a dot-dot, a short name or a name near the size limit.
  task automatic send_component(op_e op, bit closing);
    int pick;
    int len;
    pick = $urandom_range(99);
    if (pick < 24) begin
      drive_char(op, DOT);
      if (pick >= 12) drive_char(op, DOT);
    end else begin
      len = (pick < 28) ? $urandom_range(29, 34) : $urandom_range(1, 6);
      repeat (len) drive_char(op, name_char());
    end
    if (closing) repeat ($urandom_range(1, (pick % 5 == 0) ? 3 : 1)) drive_char(op, pick_sep());
  endtask

  // A whole request: base, path, finish and a few reads of the result.
  task automatic run_request();
    int                n_base;
    int                n_path;
    int                top;
    logic [RIDX_W-1:0] idx;
    n_base = $urandom_range(0, 3);
    n_path = ($urandom_range(9) == 0) ? $urandom_range(14, 19) : $urandom_range(0, 5);
    for (int i = 0; i < n_base; i++)
      send_component(OP_BASE, i < n_base - 1 || $urandom_range(1) == 1);
    if ($urandom_range(2) == 0) drive_char(OP_PATH, pick_sep());
    for (int i = 0; i < n_path; i++) begin
      send_component(OP_PATH, i < n_path - 1 || $urandom_range(3) == 0);
      if ($urandom_range(19) == 0) drive_char(OP_BASE, name_char());
      if ($urandom_range(24) == 0)
        drive_item(OP_READ, CHAR_W'($urandom), RIDX_W'($urandom));
    end
    drive_item(OP_FINISH, CHAR_W'($urandom), RIDX_W'($urandom));
    if ($urandom_range(4) == 0) drive_item(OP_FINISH, CHAR_W'($urandom), RIDX_W'($urandom));
    repeat ($urandom_range(0, 6)) begin
      top = (tail_len + 1 > 511) ? 511 : tail_len + 1;
      if ($urandom_range(4) == 0) idx = RIDX_W'($urandom_range(511));
      else idx = RIDX_W'($urandom_range(0, top));
      drive_item(OP_READ, CHAR_W'($urandom), idx);
    end
  endtask

  // Stops offering items and waits for every expected result.
  task automatic wait_drained();
    s_tvalid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] value);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i    <= 1'b0;
    capacity_model = value;
  endtask

  // Main sequence: reset, directed rows, then random phases.
  initial begin
    path_result_t     row_res;
    logic [CAP_W-1:0] cap;
    int               target;
    rst_ni         = 1'b0;
    s_tvalid_i     = 1'b0;
    s_tdata_i      = '0;
    s_tuser_i      = '0;
    cfg_valid_i    = 1'b0;
    cfg_data_i     = '0;
    fail_count     = 0;
    items_sent     = 0;
    hold_pending   = 1'b0;
    src_idle_pct   = 35;
    sink_idle_pct  = 72;
    capacity_model = CAP_RESET;
    path_begun     = 1'b0;
    req_closed     = 1'b1;
    drop_request();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (DIRECTED_ROWS[i]) begin
      row_res.status = DIRECTED_ROWS[i].st;
      row_res.length = DIRECTED_ROWS[i].len;
      row_res.chr    = DIRECTED_ROWS[i].ch;
      drive_item(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].c, DIRECTED_ROWS[i].idx,
                 DIRECTED_ROWS[i].typed, row_res);
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: cap = 10'd0;
        1: cap = 10'd512;
        2: cap = 10'd1;
        3: cap = CAP_W'($urandom_range(2, 511));
        4: cap = 10'd24;
        default: cap = CAP_RESET;
      endcase
      write_capacity(cap);
      src_idle_pct  = (ph < 2) ? 35 : (ph < 4) ? 72 : 0;
      sink_idle_pct = (ph < 2) ? 72 : (ph < 4) ? 35 : 0;
      // Back-pressure burst: the sink holds off while items keep coming.
      if (ph == 0 || ph == 4) hold_pending = 1'b1;
      target = items_sent + RANDOM_ITEMS / NUM_PHASES;
      while (items_sent < target) begin
        if ($urandom_range(99) < 8) begin
          repeat ($urandom_range(1, 8))
            drive_item(op_e'($urandom_range(3)), CHAR_W'($urandom), RIDX_W'($urandom));
        end else begin
          run_request();
        end
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("** path_normalizer_unit: PASSED **");
    end else begin
      $display("** path_normalizer_unit: FAILED **");
    end
    $finish;
  end

endmodule
